@@ rtl/efc_pkg.sv @@
// Package for the elevator floor controller core: operation and motion codes,
// field widths. No dependencies.
`default_nettype none
package efc_pkg;

  // Width of every floor number on the ports
  localparam int FloorW = 4;
  // Width of the lamp and stop-request words on the ports
  localparam int LampW  = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_STATUS  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    MOTION_UP   = 2'd0,
    MOTION_DOWN = 2'd1,
    MOTION_STOP = 2'd2
  } motion_e;

endpackage
`default_nettype wire

@@ rtl/elevator_floor_controller_core.sv @@
// Elevator floor controller core: car state, stop requests, target search and
// a registered status word per input word. Depends on efc_pkg.
//
// Each accepted input word's status word is held in the output register.
// Throughput: one word per cycle; the single output register frees in the same
// cycle its word is taken, so input ready follows out_ready_i when it is full.
// The target search is a combinational priority pick over FLOOR_COUNT stop bits.
// Reset (rst_ni low, asynchronous): car, previous and target floor 0, no stops,
// door closed, output register empty.
`default_nettype none
module elevator_floor_controller_core #(
  parameter int FLOOR_COUNT = 5
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Input words
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic [efc_pkg::FloorW-1:0] floor_number_i,
  // Status words
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [efc_pkg::FloorW-1:0]      current_floor_o,
  output logic [efc_pkg::FloorW-1:0]      previous_floor_o,
  output logic [efc_pkg::FloorW-1:0]      target_floor_o,
  output logic                            door_open_o,
  output logic [1:0]                      motion_o,
  output logic [efc_pkg::LampW-1:0]       floor_lamps_o,
  output logic                            move_report_o,
  output logic [efc_pkg::LampW-1:0]       pending_stops_o
);

  localparam int FW = efc_pkg::FloorW;
  localparam logic [FW:0]   FloorCnt = (FW + 1)'(FLOOR_COUNT);
  localparam logic [FW-1:0] TopFloor = FW'(FLOOR_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Car state
  // ---------------------------------------------------------------------------
  logic [FW-1:0]          car_q, car_d;
  logic [FW-1:0]          last_q, last_d;
  logic [FW-1:0]          goal_q, goal_d;
  logic [FLOOR_COUNT-1:0] stop_q, stop_d;
  logic                   door_q, door_d;

  // Output register
  logic                   out_valid_q;
  logic [FW-1:0]          res_car_q, res_last_q, res_goal_q;
  logic                   res_door_q, res_moved_q;
  logic [1:0]             res_motion_q;
  logic [FLOOR_COUNT-1:0] res_stop_q;

  logic                   in_fire;
  logic                   moved_d;
  efc_pkg::motion_e       motion_d;

  // Accept whenever the output register is empty or being emptied this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Target search. Travelling up (or standing): nearest stop at or above the
  // car, else nearest below. Travelling down: nearest at or below, else
  // nearest above. No stop at all: hold the current floor.
  // ---------------------------------------------------------------------------
  logic          hit_ge, hit_lt, hit_le, hit_gt;
  logic [FW-1:0] pick_ge, pick_lt, pick_le, pick_gt;
  logic [FW-1:0] next_goal;

  always_comb begin
    hit_ge  = 1'b0;
    hit_gt  = 1'b0;
    pick_ge = '0;
    pick_gt = '0;
    // Descend so the lowest matching floor wins
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      if (stop_q[i] && (FW'(i) >= car_q)) begin
        hit_ge  = 1'b1;
        pick_ge = FW'(i);
      end
      if (stop_q[i] && (FW'(i) > car_q)) begin
        hit_gt  = 1'b1;
        pick_gt = FW'(i);
      end
    end
  end

  always_comb begin
    hit_le  = 1'b0;
    hit_lt  = 1'b0;
    pick_le = '0;
    pick_lt = '0;
    // Ascend so the highest matching floor wins
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (stop_q[i] && (FW'(i) <= car_q)) begin
        hit_le  = 1'b1;
        pick_le = FW'(i);
      end
      if (stop_q[i] && (FW'(i) < car_q)) begin
        hit_lt  = 1'b1;
        pick_lt = FW'(i);
      end
    end
  end

  always_comb begin
    if (last_q <= car_q) begin
      priority if (hit_ge) next_goal = pick_ge;
      else if (hit_lt)     next_goal = pick_lt;
      else                 next_goal = car_q;
    end else begin
      priority if (hit_le) next_goal = pick_le;
      else if (hit_gt)     next_goal = pick_gt;
      else                 next_goal = car_q;
    end
  end

  // ---------------------------------------------------------------------------
  // One-floor step. Keep the last direction of travel; when standing, head for
  // the target. Turn back at the top and bottom floors.
  // ---------------------------------------------------------------------------
  logic          go_up;
  logic [FW-1:0] step_floor;

  always_comb begin
    priority if (car_q > last_q) go_up = 1'b1;
    else if (car_q < last_q)     go_up = 1'b0;
    else                         go_up = (car_q < goal_q);

    if (go_up) begin
      step_floor = (car_q < TopFloor) ? car_q + FW'(1) : car_q - FW'(1);
    end else begin
      step_floor = (car_q > '0) ? car_q - FW'(1) : car_q + FW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state for one input word
  // ---------------------------------------------------------------------------
  always_comb begin
    car_d   = car_q;
    last_d  = last_q;
    goal_d  = goal_q;
    stop_d  = stop_q;
    door_d  = door_q;
    moved_d = 1'b0;

    unique case (opcode_i)
      efc_pkg::OP_TICK: begin
        last_d = car_q;
        if (car_q == goal_q) begin
          // At target: pick the next one, drop this floor's stop, open the door
          goal_d = next_goal;
          stop_d = stop_q & ~(FLOOR_COUNT'(1) << car_q);
          door_d = 1'b1;
        end else begin
          car_d  = step_floor;
          door_d = 1'b0;
        end
        moved_d = !((car_d == goal_d) && (car_d == last_d));
      end
      efc_pkg::OP_REQUEST: begin
        // Drop requests beyond the top floor
        if ({1'b0, floor_number_i} < FloorCnt) begin
          stop_d = stop_q | (FLOOR_COUNT'(1) << floor_number_i);
        end
      end
      efc_pkg::OP_STATUS: begin
      end
      default: begin
      end
    endcase

    priority if (car_d < goal_d) motion_d = efc_pkg::MOTION_UP;
    else if (car_d > goal_d)     motion_d = efc_pkg::MOTION_DOWN;
    else                         motion_d = efc_pkg::MOTION_STOP;
  end

  // ---------------------------------------------------------------------------
  // State and output registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q       <= '0;
      last_q      <= '0;
      goal_q      <= '0;
      stop_q      <= '0;
      door_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        car_q  <= car_d;
        last_q <= last_d;
        goal_q <= goal_d;
        stop_q <= stop_d;
        door_q <= door_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the status word: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_car_q    <= car_d;
      res_last_q   <= last_d;
      res_goal_q   <= goal_d;
      res_door_q   <= door_d;
      res_motion_q <= motion_d;
      res_moved_q  <= moved_d;
      res_stop_q   <= stop_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign current_floor_o  = res_car_q;
  assign previous_floor_o = res_last_q;
  assign target_floor_o   = res_goal_q;
  assign door_open_o      = res_door_q;
  assign motion_o         = res_motion_q;
  assign move_report_o    = res_moved_q;
  assign floor_lamps_o    = efc_pkg::LampW'(1) << res_car_q;
  assign pending_stops_o  = efc_pkg::LampW'(res_stop_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The car never leaves the served floors
  a_car_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, car_q} < FloorCnt)
    else $error("car floor out of range");

  // The target is always a served floor
  a_goal_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, goal_q} < FloorCnt)
    else $error("target floor out of range");

  // The door only opens while the car stands still
  a_door_standing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    door_q |-> (last_q == car_q))
    else $error("door open while car moved");

  // A tick away from the target always moves the car
  a_tick_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (opcode_i == efc_pkg::OP_TICK) && (car_q != goal_q))
    |=> (car_q != $past(car_q)))
    else $error("tick away from target did not move the car");

endmodule
`default_nettype wire
